### rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    // Fixed field widths of the request and result channels
    localparam int TRIT_W    = 2;
    localparam int IDX_W     = 10;
    localparam int CNT_OUT_W = 11;

    // Trit encodings
    localparam logic [TRIT_W-1:0] TRIT_UNK     = 2'd0;
    localparam logic [TRIT_W-1:0] TRIT_FALSE   = 2'd1;
    localparam logic [TRIT_W-1:0] TRIT_TRUE    = 2'd2;
    localparam logic [TRIT_W-1:0] TRIT_INVALID = 2'd3;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TRIM  = 2'd2,
        REQ_LEN   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_READ,
        S_PROC,
        S_DONE
    } t_state;

    // Word store control strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

### rtl/packed_trit_store_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Packed trit store. Holds up to 1024 ternary values (unknown, false, true),
// two bits each, in a word memory of WORD_BITS-bit words. Reset marks every
// word unwritten at once through per-word valid bits, so there is no clearing
// pass and the block is ready in the cycle after reset. Requests: write one
// trit (extends the used range), read one trit (unknown past the range), trim
// from an index (clears that trit and all later ones), length query (highest
// non-unknown index plus one). Every result carries the running true, false
// and unknown counts and the last used index. One request is worked at a time
// by a small sequencer around one shared word unit and the memory's single
// read and write port. A read or a write visits one memory word; a trim visits
// the words from the trim index's word through the last used index's word; a
// length query visits the words from word 0 through the last used one. An
// ignored request (invalid write code, write index not below DEPTH, read or
// trim past the range) visits no word and goes straight to the final step.
// The request port reopens in the same cycle that the result is offered; a
// result that is not yet taken holds the sequencer at its final step until the
// output register frees.
module packed_trit_store_core #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_req_type,
    input  wire logic [pts_pkg::IDX_W-1:0]         i_trit_index,
    input  wire logic [pts_pkg::TRIT_W-1:0]        i_trit_value,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [pts_pkg::TRIT_W-1:0]        o_read_trit,
    output logic      [pts_pkg::CNT_OUT_W-1:0]     o_true_count,
    output logic      [pts_pkg::CNT_OUT_W-1:0]     o_false_count,
    output logic      [pts_pkg::CNT_OUT_W-1:0]     o_unknown_count,
    output logic      [pts_pkg::IDX_W-1:0]         o_last_index,
    output logic      [pts_pkg::CNT_OUT_W-1:0]     o_set_length
);
    import pts_pkg::*;

    // Only indexes below 2**IDX_W can ever arrive, so storage stops there.
    localparam int USED_DEPTH = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
    localparam int TPW        = WORD_BITS / 2;
    localparam int NUM_WORDS  = (USED_DEPTH + TPW - 1) / TPW;
    localparam int WI_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W      = $clog2(TPW);
    localparam int CNT_W      = $clog2(TPW + 1);
    // index / TPW by reciprocal multiply; exact for all IDX_W-bit indexes
    // since TPW stays below 2**(MUL_SHIFT - IDX_W)
    localparam int MUL_SHIFT  = 16;
    localparam int RECIP      = ((1 << MUL_SHIFT) + TPW - 1) / TPW;
    localparam int PROD_W     = MUL_SHIFT + IDX_W;
    localparam int BASE_W     = IDX_W + 1;
    localparam int SUM_W      = IDX_W + 2;

    // Sequencer and request context
    t_state                 r_state, n_state;
    t_req                   r_req, n_req;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [TRIT_W-1:0]      r_val, n_val;
    logic [WI_W-1:0]        r_word, n_word;
    logic [BASE_W-1:0]      r_base, n_base;
    logic [OFF_W-1:0]       r_off, n_off;

    // Architectural state
    logic [IDX_W-1:0]       r_last, n_last;
    logic [CNT_OUT_W-1:0]   r_true, n_true;
    logic [CNT_OUT_W-1:0]   r_false, n_false;

    // Per-request results
    logic [TRIT_W-1:0]      r_rd_trit, n_rd_trit;
    logic [CNT_OUT_W-1:0]   r_len, n_len;

    // Output register
    logic                   r_o_valid, n_o_valid;
    logic [TRIT_W-1:0]      r_o_trit;
    logic [CNT_OUT_W-1:0]   r_o_true, r_o_false, r_o_unk, r_o_len;
    logic [IDX_W-1:0]       r_o_last;

    // Memory and word unit hookup
    t_mem_ctl               w_mem_ctl;
    logic [WORD_BITS-1:0]   w_rd_data;
    logic [2*TPW-1:0]       w_new_word;
    logic                   w_single;
    logic [TRIT_W-1:0]      w_put_val;
    logic [CNT_W-1:0]       w_cnt_true, w_cnt_false;
    logic [TRIT_W-1:0]      w_old_trit;
    logic                   w_any_set;
    logic [OFF_W-1:0]       w_top_pos;

    // Decode
    logic                   w_accept;
    logic                   w_go;
    logic                   w_last_word;
    logic                   w_load_out;
    logic [PROD_W-1:0]      w_prod;
    logic [BASE_W-1:0]      w_base_mul;
    logic [CNT_OUT_W-1:0]   w_put_true, w_put_false;

    assign w_accept = i_in_valid && o_in_ready;

    // Does the request touch the memory at all?
    always_comb begin
        case (t_req'(i_req_type))
            REQ_WRITE: w_go = (i_trit_value != TRIT_INVALID) &&
                              ({1'b0, i_trit_index} < BASE_W'(USED_DEPTH));
            REQ_READ:  w_go = (i_trit_index <= r_last);
            REQ_TRIM:  w_go = (i_trit_index <= r_last);
            default:   w_go = 1'b1;
        endcase
    end

    // Scan ends at the word that holds the last used index
    assign w_last_word = (SUM_W'(r_base) + SUM_W'(TPW)) > SUM_W'(r_last);
    assign w_load_out  = (r_state == S_DONE) && (!r_o_valid || i_out_ready);

    assign w_prod     = PROD_W'(r_idx) * PROD_W'(RECIP);
    assign w_base_mul = BASE_W'(r_word) * BASE_W'(TPW);

    assign w_single   = (r_req == REQ_WRITE);
    assign w_put_val  = (r_req == REQ_WRITE) ? r_val : TRIT_UNK;
    assign w_put_true  = ((r_req == REQ_WRITE) && (r_val == TRIT_TRUE))
                         ? CNT_OUT_W'(1) : '0;
    assign w_put_false = ((r_req == REQ_WRITE) && (r_val == TRIT_FALSE))
                         ? CNT_OUT_W'(1) : '0;

    pts_store #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS),
        .WI_W      (WI_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (r_word),
        .i_wr_addr (r_word),
        .i_wr_data (w_new_word),
        .o_rd_data (w_rd_data)
    );

    pts_word_unit #(
        .TPW   (TPW),
        .OFF_W (OFF_W),
        .CNT_W (CNT_W)
    ) u_word_unit (
        .i_word      (w_rd_data),
        .i_lo        (r_off),
        .i_single    (w_single),
        .i_value     (w_put_val),
        .o_word      (w_new_word),
        .o_cnt_true  (w_cnt_true),
        .o_cnt_false (w_cnt_false),
        .o_old_trit  (w_old_trit),
        .o_any_set   (w_any_set),
        .o_top_pos   (w_top_pos)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_go) begin
                        n_state = S_DONE;
                    end else if (t_req'(i_req_type) == REQ_LEN) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV:  n_state = S_REM;
            S_REM:  n_state = S_READ;
            S_READ: n_state = S_PROC;
            S_PROC: begin
                if ((r_req == REQ_WRITE) || (r_req == REQ_READ) || w_last_word) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready      = 1'b0;
        w_mem_ctl.rd_en = 1'b0;
        w_mem_ctl.wr_en = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_READ: w_mem_ctl.rd_en = 1'b1;
            S_PROC: w_mem_ctl.wr_en = (r_req == REQ_WRITE) || (r_req == REQ_TRIM);
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_req     = r_req;
        n_idx     = r_idx;
        n_val     = r_val;
        n_word    = r_word;
        n_base    = r_base;
        n_off     = r_off;
        n_last    = r_last;
        n_true    = r_true;
        n_false   = r_false;
        n_rd_trit = r_rd_trit;
        n_len     = r_len;
        n_o_valid = r_o_valid;
        if (i_out_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req     = t_req'(i_req_type);
                    n_idx     = i_trit_index;
                    n_val     = i_trit_value;
                    n_word    = '0;
                    n_base    = '0;
                    n_off     = '0;
                    n_rd_trit = TRIT_UNK;
                    n_len     = '0;
                end
            end
            S_DIV: n_word = w_prod[MUL_SHIFT +: WI_W];
            S_REM: begin
                n_base = w_base_mul;
                n_off  = OFF_W'(BASE_W'(r_idx) - w_base_mul);
            end
            S_PROC: begin
                n_true  = r_true - CNT_OUT_W'(w_cnt_true) + w_put_true;
                n_false = r_false - CNT_OUT_W'(w_cnt_false) + w_put_false;
                if (r_req == REQ_READ) begin
                    n_true    = r_true;
                    n_false   = r_false;
                    n_rd_trit = w_old_trit;
                end
                if (r_req == REQ_LEN) begin
                    n_true  = r_true;
                    n_false = r_false;
                    if (w_any_set) begin
                        n_len = CNT_OUT_W'(r_base) + CNT_OUT_W'(w_top_pos) + CNT_OUT_W'(1);
                    end
                end
                if ((r_req == REQ_WRITE) && (r_idx > r_last)) begin
                    n_last = r_idx;
                end
                // step to the next word of a scan
                n_word = r_word + WI_W'(1);
                n_base = r_base + BASE_W'(TPW);
                n_off  = '0;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_o_valid = 1'b1;
                end
            end
            default: begin
                n_req = r_req;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_true    <= '0;
            r_false   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_true    <= n_true;
            r_false   <= n_false;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_word    <= n_word;
        r_base    <= n_base;
        r_off     <= n_off;
        r_rd_trit <= n_rd_trit;
        r_len     <= n_len;
        if (w_load_out) begin
            r_o_trit  <= r_rd_trit;
            r_o_true  <= r_true;
            r_o_false <= r_false;
            r_o_unk   <= CNT_OUT_W'(r_last) + CNT_OUT_W'(1) - r_true - r_false;
            r_o_last  <= r_last;
            r_o_len   <= r_len;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_read_trit     = r_o_trit;
    assign o_true_count    = r_o_true;
    assign o_false_count   = r_o_false;
    assign o_unknown_count = r_o_unk;
    assign o_last_index    = r_o_last;
    assign o_set_length    = r_o_len;

`ifndef SYNTH
    // Known trits can never outnumber the used range
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_true) + SUM_W'(r_false)) <= (SUM_W'(r_last) + SUM_W'(1)))
        else $error("trit counts exceed used range");

    // A transfer in closes the request port until the result is offered
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request taken while busy");

    // Reads and length queries never modify the store
    a_no_write_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.wr_en |-> ((r_req == REQ_WRITE) || (r_req == REQ_TRIM)))
        else $error("store written by a query");

    // A new result appears only from the final sequencer step
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result offered outside final step");
`endif

endmodule

`default_nettype wire

### rtl/pts_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared per-word unit: replaces a selected trit range with a value and
// reports what it held.
module pts_word_unit #(
    parameter int TPW   = 16,
    parameter int OFF_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic [2*TPW-1:0]           i_word,
    input  wire logic [OFF_W-1:0]           i_lo,
    input  wire logic                       i_single,
    input  wire logic [pts_pkg::TRIT_W-1:0] i_value,
    output logic      [2*TPW-1:0]           o_word,
    output logic      [CNT_W-1:0]           o_cnt_true,
    output logic      [CNT_W-1:0]           o_cnt_false,
    output logic      [pts_pkg::TRIT_W-1:0] o_old_trit,
    output logic                            o_any_set,
    output logic      [OFF_W-1:0]           o_top_pos
);
    import pts_pkg::*;

    always_comb begin
        logic [TRIT_W-1:0] t;
        logic              sel;
        o_word      = i_word;
        o_cnt_true  = '0;
        o_cnt_false = '0;
        o_old_trit  = TRIT_UNK;
        o_any_set   = 1'b0;
        o_top_pos   = '0;
        for (int k = 0; k < TPW; k++) begin
            t   = i_word[2*k +: TRIT_W];
            sel = i_single ? (OFF_W'(k) == i_lo) : (OFF_W'(k) >= i_lo);
            if (OFF_W'(k) == i_lo) begin
                o_old_trit = t;
            end
            if (sel) begin
                o_word[2*k +: TRIT_W] = i_value;
                if (t == TRIT_TRUE) begin
                    o_cnt_true = o_cnt_true + CNT_W'(1);
                end
                if (t == TRIT_FALSE) begin
                    o_cnt_false = o_cnt_false + CNT_W'(1);
                end
            end
            if (t != TRIT_UNK) begin
                o_any_set = 1'b1;
                o_top_pos = OFF_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pts_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port-per-direction word memory; a word never written reads as zero.
module pts_store #(
    parameter int NUM_WORDS = 64,
    parameter int WORD_BITS = 32,
    parameter int WI_W      = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pts_pkg::t_mem_ctl     i_ctl,
    input  wire logic [WI_W-1:0]       i_rd_addr,
    input  wire logic [WI_W-1:0]       i_wr_addr,
    input  wire logic [WORD_BITS-1:0]  i_wr_data,
    output logic      [WORD_BITS-1:0]  o_rd_data
);
    import pts_pkg::*;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rd_word;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_word : '0;

endmodule

`default_nettype wire

### test/tb_packed_trit_store_core.sv
`timescale 1ns / 1ps

module tb_packed_trit_store_core;
    import pts_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 530;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int NUM_TRITS    = 1024;

    // One result transfer, field by field
    typedef struct packed {
        logic [TRIT_W-1:0]    rd;
        logic [CNT_OUT_W-1:0] n_true;
        logic [CNT_OUT_W-1:0] n_false;
        logic [CNT_OUT_W-1:0] n_unk;
        logic [IDX_W-1:0]     last;
        logic [CNT_OUT_W-1:0] length;
    } t_trit_result;

    // Directed row: request plus an optional hand-written result
    typedef struct packed {
        t_req              req;
        logic [IDX_W-1:0]  idx;
        logic [TRIT_W-1:0] val;
        logic              typed;
        t_trit_result      want;
    } t_stim_row;

    localparam t_trit_result NO_VIEW    = '0;
    // Fresh store: one unknown trit in the range, nothing else
    localparam t_trit_result RESET_VIEW = '{TRIT_UNK, 11'd0, 11'd0, 11'd1, 10'd0, 11'd0};

    localparam t_stim_row DIRECTED [24] = '{
        '{REQ_LEN,   10'd0,    TRIT_UNK,     1'b1, RESET_VIEW},
        '{REQ_READ,  10'd1023, TRIT_UNK,     1'b1, RESET_VIEW},  // past the range
        '{REQ_WRITE, 10'd1023, TRIT_INVALID, 1'b1, RESET_VIEW},  // bad code, no extend
        '{REQ_WRITE, 10'd5,    TRIT_UNK,     1'b1,
          '{TRIT_UNK, 11'd0, 11'd0, 11'd6, 10'd5, 11'd0}},       // unknown still extends
        '{REQ_WRITE, 10'd0,    TRIT_TRUE,    1'b0, NO_VIEW},
        '{REQ_WRITE, 10'd3,    TRIT_FALSE,   1'b0, NO_VIEW},
        '{REQ_TRIM,  10'd100,  TRIT_UNK,     1'b0, NO_VIEW},     // trim past the range
        '{REQ_READ,  10'd0,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_READ,  10'd3,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_READ,  10'd6,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_LEN,   10'd0,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_WRITE, 10'd682,  TRIT_FALSE,   1'b0, NO_VIEW},
        '{REQ_WRITE, 10'd341,  TRIT_TRUE,    1'b0, NO_VIEW},
        '{REQ_WRITE, 10'd1023, TRIT_TRUE,    1'b0, NO_VIEW},
        '{REQ_READ,  10'd1023, TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_LEN,   10'd0,    TRIT_UNK,     1'b0, NO_VIEW},     // full length 1024
        '{REQ_WRITE, 10'd3,    TRIT_TRUE,    1'b0, NO_VIEW},     // false -> true
        '{REQ_WRITE, 10'd0,    TRIT_UNK,     1'b0, NO_VIEW},     // true -> unknown
        '{REQ_TRIM,  10'd1023, TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_LEN,   10'd0,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_TRIM,  10'd4,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_READ,  10'd341,  TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_TRIM,  10'd0,    TRIT_UNK,     1'b0, NO_VIEW},
        '{REQ_LEN,   10'd0,    TRIT_UNK,     1'b0, NO_VIEW}
    };

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [1:0]           i_req_type   = REQ_WRITE;
    logic [IDX_W-1:0]     i_trit_index = '0;
    logic [TRIT_W-1:0]    i_trit_value = TRIT_UNK;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [TRIT_W-1:0]    o_read_trit;
    logic [CNT_OUT_W-1:0] o_true_count;
    logic [CNT_OUT_W-1:0] o_false_count;
    logic [CNT_OUT_W-1:0] o_unknown_count;
    logic [IDX_W-1:0]     o_last_index;
    logic [CNT_OUT_W-1:0] o_set_length;

    packed_trit_store_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_trit_index    (i_trit_index),
        .i_trit_value    (i_trit_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_trit     (o_read_trit),
        .o_true_count    (o_true_count),
        .o_false_count   (o_false_count),
        .o_unknown_count (o_unknown_count),
        .o_last_index    (o_last_index),
        .o_set_length    (o_set_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the store contents and running counts
    logic [TRIT_W-1:0] mirror_trits [NUM_TRITS];
    logic [IDX_W-1:0]  mirror_last;
    int                mirror_true;
    int                mirror_false;

    t_trit_result      pending_results [$];
    int                mismatches = 0;
    bit                steady     = 1'b0;   // no gaps on either side
    bit                hold_off   = 1'b0;   // asks the receiver for one long stall

    function automatic void set_trit(int idx, logic [TRIT_W-1:0] val);
        if (mirror_trits[idx] == TRIT_TRUE) mirror_true--;
        else if (mirror_trits[idx] == TRIT_FALSE) mirror_false--;
        if (val == TRIT_TRUE) mirror_true++;
        else if (val == TRIT_FALSE) mirror_false++;
        mirror_trits[idx] = val;
    endfunction

    // Applies one request to the mirror and returns the result it yields
    function automatic t_trit_result apply_request(t_req req, logic [IDX_W-1:0] idx,
                                                   logic [TRIT_W-1:0] val);
        t_trit_result r;
        int           i;
        r = '0;
        case (req)
            REQ_WRITE: begin
                if (val != TRIT_INVALID) begin
                    set_trit(int'(idx), val);
                    if (idx > mirror_last) mirror_last = idx;
                end
            end
            REQ_READ: begin
                if (idx <= mirror_last) r.rd = mirror_trits[idx];
            end
            REQ_TRIM: begin
                for (i = int'(idx); i <= int'(mirror_last); i++) set_trit(i, TRIT_UNK);
            end
            default: begin
                for (i = 0; i <= int'(mirror_last); i++)
                    if (mirror_trits[i] != TRIT_UNK) r.length = CNT_OUT_W'(i + 1);
            end
        endcase
        r.n_true  = CNT_OUT_W'(mirror_true);
        r.n_false = CNT_OUT_W'(mirror_false);
        r.n_unk   = CNT_OUT_W'(int'(mirror_last) + 1 - mirror_true - mirror_false);
        r.last    = mirror_last;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic check_result();
        t_trit_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing pending", 1, 0);
            return;
        end
        want = pending_results.pop_front();
        if (o_read_trit !== want.rd)
            flag_mismatch("read_trit", int'(o_read_trit), int'(want.rd));
        if (o_true_count !== want.n_true)
            flag_mismatch("true_count", int'(o_true_count), int'(want.n_true));
        if (o_false_count !== want.n_false)
            flag_mismatch("false_count", int'(o_false_count), int'(want.n_false));
        if (o_unknown_count !== want.n_unk)
            flag_mismatch("unknown_count", int'(o_unknown_count), int'(want.n_unk));
        if (o_last_index !== want.last)
            flag_mismatch("last_index", int'(o_last_index), int'(want.last));
        if (o_set_length !== want.length)
            flag_mismatch("set_length", int'(o_set_length), int'(want.length));
    endtask

    // Offer one request and hold it until the transfer; called at a rising edge
    task automatic offer(t_req req, logic [IDX_W-1:0] idx, logic [TRIT_W-1:0] val,
                         logic typed, t_trit_result want);
        t_trit_result predicted;
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_trit_index <= idx;
        i_trit_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_request(req, idx, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index(int hot_base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return IDX_W'(hot_base + int'($urandom_range(0, 47)));
        if (r < 85) return IDX_W'($urandom_range(0, NUM_TRITS - 1));
        return IDX_W'($urandom_range(NUM_TRITS - 32, NUM_TRITS - 1));
    endfunction

    // Result side: checks each transfer and toggles ready in runs and stalls
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_result();
            if (hold_off) begin
                hold_off   = 1'b0;
                stall_left = HOLD_CYCLES;
                run_left   = 1;
            end
            if (stall_left == 0 && run_left == 0) begin
                stall_left = pick_gap();
                run_left   = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                run_left--;
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        int cycle_count;
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int                k;
        int                n;
        int                r;
        int                hot_base;
        t_req              req;
        logic [IDX_W-1:0]  idx;
        logic [TRIT_W-1:0] val;

        for (k = 0; k < NUM_TRITS; k++) mirror_trits[k] = TRIT_UNK;
        mirror_last  = '0;
        mirror_true  = 0;
        mirror_false = 0;
        hot_base     = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < $size(DIRECTED); k++) begin
            idle_sender();
            offer(DIRECTED[k].req, DIRECTED[k].idx, DIRECTED[k].val,
                  DIRECTED[k].typed, DIRECTED[k].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 400 && n < 460);
            if (n == 150) begin
                // let the block run dry before going on
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end else begin
                idle_sender();
            end
            if (n == 300) hold_off = 1'b1;   // sender keeps offering meanwhile
            if (n % 64 == 0) hot_base = $urandom_range(0, NUM_TRITS - 48);

            r   = $urandom_range(0, 99);
            idx = pick_index(hot_base);
            val = TRIT_UNK;
            if (r < 45) begin
                req = REQ_WRITE;
                r   = $urandom_range(0, 99);
                if (r < 10) val = TRIT_INVALID;
                else if (r < 28) val = TRIT_UNK;
                else if (r < 64) val = TRIT_FALSE;
                else val = TRIT_TRUE;
            end else if (r < 72) begin
                req = REQ_READ;
            end else if (r < 82) begin
                req = REQ_TRIM;
                // mostly trim the upper part so the store does not stay empty
                if ($urandom_range(0, 99) < 65)
                    idx = IDX_W'($urandom_range(700, NUM_TRITS - 1));
            end else begin
                req = REQ_LEN;
                val = TRIT_W'($urandom_range(0, 3));
            end
            offer(req, idx, val, 1'b0, NO_VIEW);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pts_pkg.sv
rtl/pts_word_unit.sv
rtl/pts_store.sv
rtl/packed_trit_store_core.sv
test/tb_packed_trit_store_core.sv
